FILE: rtl/line_follow_pid_steer_core_assert.svh
// Assertion macros used by the checker file.
`ifndef LINE_FOLLOW_PID_STEER_CORE_ASSERT_SVH
`define LINE_FOLLOW_PID_STEER_CORE_ASSERT_SVH

// Same-cycle implication, off during reset.
`define LFPS_ASSERT_NOW(name, clk, rst_n, ant, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error("lfps check failed");

// Next-cycle implication, off during reset.
`define LFPS_ASSERT_NEXT(name, clk, rst_n, ant, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error("lfps check failed");

// Same-cycle implication that also holds while reset is asserted.
`define LFPS_ASSERT_ALWAYS(name, clk, ant, cons) \
    name: assert property (@(posedge clk) (ant) |-> (cons)) \
        else $error("lfps check failed");

`endif

FILE: rtl/lfps_pkg.sv
`default_nettype none

package lfps_pkg;

    localparam int SAMPLE_BITS_DEF = 10;
    localparam int FRAC_BITS_DEF   = 6;
    localparam int LEVEL_BITS      = 10;
    localparam int GAIN_BITS       = 16;
    localparam int GAIN_FRAC       = 8;
    localparam int CFG_DATA_BITS   = 16;
    localparam int CFG_IDX_BITS    = 3;
    localparam int INTEG_BITS      = 40;
    localparam int IHALF           = INTEG_BITS / 2;
    localparam int DIR_BITS        = 2;

    localparam logic [LEVEL_BITS-1:0] TARGET_RST = LEVEL_BITS'(70);
    localparam logic [LEVEL_BITS-1:0] KNEE_RST   = LEVEL_BITS'(60);
    localparam logic [GAIN_BITS-1:0]  CGAIN_RST  = GAIN_BITS'(59578);
    localparam logic [GAIN_BITS-1:0]  GAIN_P_RST = GAIN_BITS'(768);
    localparam logic [GAIN_BITS-1:0]  GAIN_I_RST = GAIN_BITS'(0);
    localparam logic [GAIN_BITS-1:0]  GAIN_D_RST = GAIN_BITS'(2560);
    localparam logic [LEVEL_BITS-1:0] LIMIT_RST  = LEVEL_BITS'(210);
    localparam logic [LEVEL_BITS-1:0] BOOST_RST  = LEVEL_BITS'(130);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_TARGET,
        REG_KNEE,
        REG_COMP_GAIN,
        REG_GAIN_P,
        REG_GAIN_I,
        REG_GAIN_D,
        REG_LIMIT,
        REG_BOOST
    } cfg_reg_t;

    typedef enum logic [DIR_BITS-1:0] {
        DIR_LEFT     = 2'd0,
        DIR_STRAIGHT = 2'd1,
        DIR_RIGHT    = 2'd2
    } dir_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_C,
        ST_ERR,
        ST_INTEG,
        ST_MUL_IH,
        ST_MUL_IL,
        ST_MUL_P,
        ST_MUL_D,
        ST_SUM,
        ST_CLAMP
    } seq_state_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD_HI,
        ACC_ADD,
        ACC_HALF_ADD
    } acc_op_t;

    typedef struct packed {
        logic    mul_en;
        acc_op_t acc_op;
    } mac_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/lfps_in_if.sv
`default_nettype none

interface lfps_in_if import lfps_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sensor_sample;

    modport source (output valid, output sensor_sample, input ready);
    modport sink   (input valid, input sensor_sample, output ready);
endinterface

`default_nettype wire

FILE: rtl/lfps_out_if.sv
`default_nettype none

interface lfps_out_if import lfps_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [LEVEL_BITS-1:0] drive_magnitude;
    logic [DIR_BITS-1:0]   turn_direction;
    logic                  clamped;
    logic                  boost_mode;

    modport source (output valid, output drive_magnitude, output turn_direction,
                    output clamped, output boost_mode, input ready);
    modport sink   (input valid, input drive_magnitude, input turn_direction,
                    input clamped, input boost_mode, output ready);
endinterface

`default_nettype wire

FILE: rtl/lfps_mac.sv
`default_nettype none

// Shared signed-by-unsigned multiplier with a registered product and accumulator.
module lfps_mac import lfps_pkg::*; #(
    parameter int A_BITS   = IHALF + 1,
    parameter int ACC_BITS = INTEG_BITS + GAIN_BITS + 2
) (
    input  wire  logic                                 clk,
    input  wire  mac_ctrl_t                            ctrl,
    input  wire  logic signed [A_BITS-1:0]             op_a,
    input  wire  logic        [GAIN_BITS-1:0]          op_b,
    output logic signed       [A_BITS+GAIN_BITS:0]     mul_q,
    output logic signed       [ACC_BITS-1:0]           acc_q
);

    localparam int MB = A_BITS + GAIN_BITS + 1;

    logic signed [MB-1:0]       mul_reg;
    logic signed [MB-1:0]       mul_next;
    logic signed [ACC_BITS-1:0] acc_reg;
    logic signed [ACC_BITS-1:0] acc_next;
    logic signed [ACC_BITS-1:0] mul_ext;

    assign mul_next = op_a * $signed({1'b0, op_b});
    assign mul_ext  = ACC_BITS'(mul_reg);

    always_comb
    begin
        case (ctrl.acc_op)
            ACC_LOAD_HI:  acc_next = mul_ext <<< IHALF;
            ACC_ADD:      acc_next = acc_reg + mul_ext;
            ACC_HALF_ADD: acc_next = (acc_reg >>> 1) + mul_ext;
            default:      acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            mul_reg <= mul_next;
        end
        acc_reg <= acc_next;
    end

    assign mul_q = mul_reg;
    assign acc_q = acc_reg;

endmodule

`default_nettype wire

FILE: rtl/line_follow_pid_steer_core.sv
`default_nettype none

// Line-follower steering step: one reflectance sample in, one steering result
// out. Samples above the target level are compressed toward the knee level in
// fixed point (FRAC_BITS fraction bits), the error against the target feeds a
// PID step with unsigned Q8.8 gains, a saturating 40-bit trapezoidal integral
// and a derivative from the previous error, and the sum is clamped to
// +/- drive_limit. Timing: a sample is taken only while the core is idle and
// occupies it through accept, compression multiply, error, integral update,
// five multiply/accumulate steps and the limit check, so no new sample is
// taken before the last one is through. That pace is set by the single shared
// multiplier, which handles the compression product, the integral product in
// two 20-bit halves, and the P and D products one after another. The result
// sits in an output register, so the next sample is accepted while it waits;
// only the final limit step stalls if the previous result is still untaken.
// Configuration writes land on the cycle cfg_we is high and should only come
// while no sample is in flight.
module line_follow_pid_steer_core import lfps_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    lfps_in_if.sink                       sample_ch,
    lfps_out_if.source                    result_ch,
    input  wire logic                     cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_data
);

    // Wider of the sample and the level registers.
    localparam int XB = (SAMPLE_BITS > LEVEL_BITS) ? SAMPLE_BITS : LEVEL_BITS;
    // Error width: compressed level lies between knee and sample, so it stays
    // in [0, 2^(XB+FRAC_BITS)).
    localparam int EW = XB + FRAC_BITS + 2;
    // Knee difference, signed.
    localparam int DW = XB + 1;
    // Multiplier A operand must take the P/D operands and a signed integral half.
    localparam int AB = (EW + 1 > IHALF + 1) ? EW + 1 : IHALF + 1;
    localparam int MB = AB + GAIN_BITS + 1;
    localparam int ACC_A = INTEG_BITS + GAIN_BITS + 2;
    localparam int ACC_B = EW + GAIN_BITS + 3;
    localparam int ACC_BITS = (ACC_A > ACC_B) ? ACC_A : ACC_B;
    localparam int OUT_SHIFT = FRAC_BITS + GAIN_FRAC;

    localparam logic signed [INTEG_BITS-1:0] INTEG_MAX = {1'b0, {(INTEG_BITS-1){1'b1}}};
    localparam logic signed [INTEG_BITS-1:0] INTEG_MIN = {1'b1, {(INTEG_BITS-1){1'b0}}};

    // ---------------- configuration registers ----------------
    logic [LEVEL_BITS-1:0] target_reg;
    logic [LEVEL_BITS-1:0] knee_reg;
    logic [GAIN_BITS-1:0]  cgain_reg;
    logic [GAIN_BITS-1:0]  gain_p_reg;
    logic [GAIN_BITS-1:0]  gain_i_reg;
    logic [GAIN_BITS-1:0]  gain_d_reg;
    logic [LEVEL_BITS-1:0] limit_reg;
    logic [LEVEL_BITS-1:0] boost_lvl_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg    <= TARGET_RST;
            knee_reg      <= KNEE_RST;
            cgain_reg     <= CGAIN_RST;
            gain_p_reg    <= GAIN_P_RST;
            gain_i_reg    <= GAIN_I_RST;
            gain_d_reg    <= GAIN_D_RST;
            limit_reg     <= LIMIT_RST;
            boost_lvl_reg <= BOOST_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_TARGET:    target_reg    <= cfg_data[LEVEL_BITS-1:0];
                REG_KNEE:      knee_reg      <= cfg_data[LEVEL_BITS-1:0];
                REG_COMP_GAIN: cgain_reg     <= cfg_data[GAIN_BITS-1:0];
                REG_GAIN_P:    gain_p_reg    <= cfg_data[GAIN_BITS-1:0];
                REG_GAIN_I:    gain_i_reg    <= cfg_data[GAIN_BITS-1:0];
                REG_GAIN_D:    gain_d_reg    <= cfg_data[GAIN_BITS-1:0];
                REG_LIMIT:     limit_reg     <= cfg_data[LEVEL_BITS-1:0];
                REG_BOOST:     boost_lvl_reg <= cfg_data[LEVEL_BITS-1:0];
                default:       ;
            endcase
        end
    end

    // ---------------- sequencer ----------------
    seq_state_t state_reg;
    seq_state_t state_next;
    logic       in_fire;
    logic       out_free;
    logic       out_load;

    assign in_fire  = sample_ch.valid && sample_ch.ready;
    assign out_free = !result_ch.valid || result_ch.ready;

    always_comb
    begin
        case (state_reg)
            ST_IDLE:   state_next = sample_ch.valid ? ST_MUL_C : ST_IDLE;
            ST_MUL_C:  state_next = ST_ERR;
            ST_ERR:    state_next = ST_INTEG;
            ST_INTEG:  state_next = ST_MUL_IH;
            ST_MUL_IH: state_next = ST_MUL_IL;
            ST_MUL_IL: state_next = ST_MUL_P;
            ST_MUL_P:  state_next = ST_MUL_D;
            ST_MUL_D:  state_next = ST_SUM;
            ST_SUM:    state_next = ST_CLAMP;
            ST_CLAMP:  state_next = out_free ? ST_IDLE : ST_CLAMP;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ---------------- per-sample registers ----------------
    logic [SAMPLE_BITS-1:0]       sample_reg;
    logic signed [DW-1:0]         d_reg;
    logic                         above_reg;
    logic signed [EW-1:0]         err_reg;
    logic signed [EW:0]           diff_reg;
    dir_t                         dir_reg;
    logic                         boost_reg;

    // PID state
    logic signed [EW-1:0]         prev_reg;
    logic signed [INTEG_BITS-1:0] integ_reg;

    // shared multiplier/accumulator
    mac_ctrl_t                    mac_ctrl;
    logic signed [AB-1:0]         op_a;
    logic [GAIN_BITS-1:0]         op_b;
    logic signed [MB-1:0]         mul_q;
    logic signed [ACC_BITS-1:0]   acc_q;

    lfps_mac #(
        .A_BITS   (AB),
        .ACC_BITS (ACC_BITS)
    ) u_mac (
        .clk   (clk),
        .ctrl  (mac_ctrl),
        .op_a  (op_a),
        .op_b  (op_b),
        .mul_q (mul_q),
        .acc_q (acc_q)
    );

    // Compression: knee + floor((sample - knee) * gain / 2^(16-F)).
    // Everything below wraps at EW bits; the true values fit.
    logic signed [MB-1:0]  prod_sh;
    logic [EW-1:0]         comp_w;
    logic [EW-1:0]         err_w;
    logic [EW-1:0]         boost_w;

    assign prod_sh = mul_q >>> (GAIN_BITS - FRAC_BITS);
    assign comp_w  = above_reg ? ((EW'(knee_reg) << FRAC_BITS) + EW'(prod_sh))
                               : (EW'(sample_reg) << FRAC_BITS);
    assign err_w   = comp_w - (EW'(target_reg) << FRAC_BITS);
    assign boost_w = comp_w - (EW'(boost_lvl_reg) << FRAC_BITS);

    // Integral: adds e + e_prev, saturates to the signed 40-bit range.
    logic signed [EW:0]           pair_w;
    logic signed [EW:0]           diff_w;
    logic signed [INTEG_BITS:0]   integ_ext;
    logic signed [INTEG_BITS-1:0] integ_sat;
    logic signed [IHALF-1:0]      ihi_w;

    assign pair_w    = (EW+1)'(err_reg) + (EW+1)'(prev_reg);
    assign diff_w    = (EW+1)'(err_reg) - (EW+1)'(prev_reg);
    assign integ_ext = (INTEG_BITS+1)'(integ_reg) + (INTEG_BITS+1)'(pair_w);
    assign integ_sat = (integ_ext[INTEG_BITS] != integ_ext[INTEG_BITS-1])
                     ? (integ_ext[INTEG_BITS] ? INTEG_MIN : INTEG_MAX)
                     : integ_ext[INTEG_BITS-1:0];
    assign ihi_w     = integ_reg[INTEG_BITS-1:IHALF];

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            sample_reg <= sample_ch.sensor_sample;
            d_reg      <= DW'(sample_ch.sensor_sample) - DW'(knee_reg);
            above_reg  <= XB'(sample_ch.sensor_sample) > XB'(target_reg);
        end
        if (state_reg == ST_ERR)
        begin
            err_reg   <= err_w;
            boost_reg <= !boost_w[EW-1] && (|boost_w);
            if (err_w[EW-1])
            begin
                dir_reg <= DIR_LEFT;
            end
            else if (err_w == '0)
            begin
                dir_reg <= DIR_STRAIGHT;
            end
            else
            begin
                dir_reg <= DIR_RIGHT;
            end
        end
        if (state_reg == ST_INTEG)
        begin
            diff_reg <= diff_w;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg  <= '0;
            integ_reg <= '0;
        end
        else if (state_reg == ST_INTEG)
        begin
            prev_reg  <= err_reg;
            integ_reg <= integ_sat;
        end
    end

    // Step control. The integral product is built as hi*g << 20 + lo*g, halved
    // (floor) before the P and D products are added.
    always_comb
    begin
        sample_ch.ready = (state_reg == ST_IDLE);
        out_load        = (state_reg == ST_CLAMP) && out_free;
        mac_ctrl        = '{mul_en: 1'b0, acc_op: ACC_HOLD};
        op_a            = '0;
        op_b            = '0;
        case (state_reg)
            ST_MUL_C:
            begin
                mac_ctrl.mul_en = 1'b1;
                op_a            = AB'(d_reg);
                op_b            = cgain_reg;
            end
            ST_MUL_IH:
            begin
                mac_ctrl.mul_en = 1'b1;
                op_a            = AB'(ihi_w);
                op_b            = gain_i_reg;
            end
            ST_MUL_IL:
            begin
                mac_ctrl        = '{mul_en: 1'b1, acc_op: ACC_LOAD_HI};
                op_a            = AB'(integ_reg[IHALF-1:0]);
                op_b            = gain_i_reg;
            end
            ST_MUL_P:
            begin
                mac_ctrl        = '{mul_en: 1'b1, acc_op: ACC_ADD};
                op_a            = AB'(err_reg);
                op_b            = gain_p_reg;
            end
            ST_MUL_D:
            begin
                mac_ctrl        = '{mul_en: 1'b1, acc_op: ACC_HALF_ADD};
                op_a            = AB'(diff_reg);
                op_b            = gain_d_reg;
            end
            ST_SUM:
            begin
                mac_ctrl.acc_op = ACC_ADD;
            end
            default:
            begin
            end
        endcase
    end

    // ---------------- limit and output register ----------------
    logic signed [ACC_BITS-1:0] lim_w;
    logic signed [ACC_BITS-1:0] abs_w;
    logic                       hit_w;

    assign lim_w = ACC_BITS'(limit_reg) << OUT_SHIFT;
    assign hit_w = (acc_q >= lim_w) || (acc_q <= -lim_w);
    assign abs_w = acc_q[ACC_BITS-1] ? -acc_q : acc_q;

    logic                  out_valid_reg;
    logic [LEVEL_BITS-1:0] out_mag_reg;
    dir_t                  out_dir_reg;
    logic                  out_clamp_reg;
    logic                  out_boost_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_mag_reg   <= hit_w ? limit_reg : abs_w[OUT_SHIFT +: LEVEL_BITS];
            out_clamp_reg <= hit_w;
            out_dir_reg   <= dir_reg;
            out_boost_reg <= boost_reg;
        end
    end

    assign result_ch.valid           = out_valid_reg;
    assign result_ch.drive_magnitude = out_mag_reg;
    assign result_ch.turn_direction  = out_dir_reg;
    assign result_ch.clamped         = out_clamp_reg;
    assign result_ch.boost_mode      = out_boost_reg;

endmodule

`default_nettype wire

FILE: rtl/lfps_checker.sv
`default_nettype none

`include "line_follow_pid_steer_core_assert.svh"

module lfps_checker import lfps_pkg::*; (
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  in_valid,
    input wire logic                  in_ready,
    input wire logic                  out_valid,
    input wire logic                  out_ready,
    input wire logic [LEVEL_BITS-1:0] drive_magnitude,
    input wire logic [DIR_BITS-1:0]   turn_direction,
    input wire logic                  clamped,
    input wire logic                  boost_mode
);

    // core drops ready after taking a beat
    `LFPS_ASSERT_NEXT(a_busy_after_beat, clk, rst_n, in_valid && in_ready, !in_ready)

    // no result can appear in the cycle after a beat is taken
    `LFPS_ASSERT_NEXT(a_no_early_result, clk, rst_n, in_valid && in_ready, !$rose(out_valid))

    // stalled result holds
    `LFPS_ASSERT_NEXT(a_hold_stalled, clk, rst_n, out_valid && !out_ready, out_valid && $stable(drive_magnitude) && $stable(turn_direction) && $stable(clamped) && $stable(boost_mode))

    // in reset: nothing pending, input open
    `LFPS_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n, !out_valid && in_ready)

endmodule

bind line_follow_pid_steer_core lfps_checker u_lfps_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (sample_ch.valid),
    .in_ready        (sample_ch.ready),
    .out_valid       (result_ch.valid),
    .out_ready       (result_ch.ready),
    .drive_magnitude (result_ch.drive_magnitude),
    .turn_direction  (result_ch.turn_direction),
    .clamped         (result_ch.clamped),
    .boost_mode      (result_ch.boost_mode)
);

`default_nettype wire
